@@ rtl/v3n_pkg.sv @@
// v3n_pkg: shared default widths for the vector normalizer
// used by every module under rtl; depends on nothing

package v3n_pkg;

    localparam int unsigned DEF_IN_WIDTH  = 24;
    localparam int unsigned DEF_FRAC_BITS = 16;

endpackage

@@ rtl/v3n_sqrt_stage.sv @@
// v3n_sqrt_stage: one registered step of the restoring floor square root
// depends on v3n_pkg; each stage resolves one root bit per cycle with a stall input

module v3n_sqrt_stage
    import v3n_pkg::*;
#(
    parameter int unsigned RW  = 26,
    parameter int unsigned SW  = 52,
    parameter int unsigned BIT = 0,
    parameter int unsigned PW  = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [SW-1:0] i_rem,
    input  logic [RW-1:0] i_root,
    input  logic [PW-1:0] i_pass,
    output logic          o_valid,
    output logic [SW-1:0] o_rem,
    output logic [RW-1:0] o_root,
    output logic [PW-1:0] o_pass
);

    logic [SW+1:0] w_trial;
    logic [SW+1:0] w_remx;
    logic [RW-1:0] w_set;

    // trial = (root + 2^BIT)^2 - root^2 = (root << (BIT+1)) + (1 << 2*BIT)
    // root holds only bits above BIT, so the two terms never overlap
    always_comb begin
        w_trial = ({2'b00, {(SW-RW){1'b0}}, i_root} << (BIT + 1))
                | ((SW+2)'(1) << (2*BIT));
        w_remx  = {2'b00, i_rem};
        w_set   = i_root | (RW'(1) << BIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_pass <= i_pass;
            if (w_remx >= w_trial) begin
                o_rem  <= SW'(w_remx - w_trial);
                o_root <= w_set;
            end else begin
                o_rem  <= i_rem;
                o_root <= i_root;
            end
        end
    end

endmodule

@@ rtl/v3n_div_stage.sv @@
// v3n_div_stage: one registered restoring divide step for three quotients at once
// depends on v3n_pkg; shares the divisor, carries signs and the zero flag

module v3n_div_stage
    import v3n_pkg::*;
#(
    parameter int unsigned NW  = 41,
    parameter int unsigned DW  = 26,
    parameter int unsigned BIT = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_den,
    input  logic [NW-1:0] i_rem  [3],
    input  logic [NW-1:0] i_quo  [3],
    input  logic [3:0]    i_flags,
    output logic          o_valid,
    output logic [DW-1:0] o_den,
    output logic [NW-1:0] o_rem  [3],
    output logic [NW-1:0] o_quo  [3],
    output logic [3:0]    o_flags
);

    logic [NW+DW:0] w_sh;
    logic [NW+DW:0] w_r [3];

    always_comb begin
        w_sh = {{(NW+1){1'b0}}, i_den} << BIT;
        for (int k = 0; k < 3; k++) begin
            w_r[k] = {{(DW+1){1'b0}}, i_rem[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_den   <= i_den;
            o_flags <= i_flags;
            for (int k = 0; k < 3; k++) begin
                if (w_r[k] >= w_sh) begin
                    o_rem[k] <= NW'(w_r[k] - w_sh);
                    o_quo[k] <= i_quo[k] | (NW'(1) << BIT);
                end else begin
                    o_rem[k] <= i_rem[k];
                    o_quo[k] <= i_quo[k];
                end
            end
        end
    end

endmodule

@@ rtl/vector3_normalize_core.sv @@
// vector3_normalize_core: pipelined 3d vector normalizer, signed Q7.16 in, Q1.16 out
// stages: magnitudes, square sum, square root chain, divide chain, output; one item per cycle unless stalled;
// the depth is set by one root bit per square root stage and one quotient bit per divide stage
// a full output register with skid-free global stall: all stages hold while output waits
// reset (i_rst_n low, synchronous) clears every valid bit; payload registers are not reset
// depends on v3n_pkg, v3n_sqrt_stage and v3n_div_stage

module vector3_normalize_core
    import v3n_pkg::*;
#(
    parameter int unsigned IN_WIDTH  = DEF_IN_WIDTH,
    parameter int unsigned FRAC_BITS = DEF_FRAC_BITS,
    localparam int unsigned OW = FRAC_BITS + 2,
    localparam int unsigned IBYTES = (3*IN_WIDTH + 7) / 8,
    localparam int unsigned OBYTES = (3*OW + 1 + 7) / 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // comp_x, comp_y, comp_z from bit 0 up, zero filled
    input  logic [IBYTES*8-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // unit_x, unit_y, unit_z, zero_length from bit 0 up, zero filled
    output logic [OBYTES*8-1:0] m_axis_tdata
);

    localparam int unsigned MW = IN_WIDTH;          // magnitude width (most negative fits)
    localparam int unsigned SW = 2*MW + 2;          // sum of three squares
    localparam int unsigned RW = MW + 1;            // root width
    localparam int unsigned NW = MW + FRAC_BITS;    // dividend width
    localparam int unsigned QB = OW;                // quotient bits computed (up to 2^(OW-1))

    logic w_en;
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    // stage 1: magnitudes and signs
    logic              r1_v;
    logic [MW-1:0]     r1_mag [3];
    logic [2:0]        r1_neg;
    // stage 2: squares summed
    logic              r2_v;
    logic [SW-1:0]     r2_sum;
    logic [MW-1:0]     r2_mag [3];
    logic [2:0]        r2_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= s_axis_tvalid;
            r2_v <= r1_v;
        end
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                logic [IN_WIDTH-1:0] c;
                c = s_axis_tdata[k*IN_WIDTH +: IN_WIDTH];
                r1_neg[k] <= c[IN_WIDTH-1];
                r1_mag[k] <= c[IN_WIDTH-1] ? MW'(-c) : c;
            end
            r2_sum <= SW'({{MW{1'b0}}, r1_mag[0]} * {{MW{1'b0}}, r1_mag[0]})
                    + SW'({{MW{1'b0}}, r1_mag[1]} * {{MW{1'b0}}, r1_mag[1]})
                    + SW'({{MW{1'b0}}, r1_mag[2]} * {{MW{1'b0}}, r1_mag[2]});
            r2_mag <= r1_mag;
            r2_neg <= r1_neg;
        end
    end

    // square root chain, payload carries magnitudes and signs
    localparam int unsigned PW = 3*MW + 3;
    logic          s_v    [RW+1];
    logic [SW-1:0] s_rem  [RW+1];
    logic [RW-1:0] s_root [RW+1];
    logic [PW-1:0] s_pass [RW+1];

    assign s_v[0]    = r2_v;
    assign s_rem[0]  = r2_sum;
    assign s_root[0] = '0;
    assign s_pass[0] = {r2_neg, r2_mag[2], r2_mag[1], r2_mag[0]};

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        v3n_sqrt_stage #(.RW(RW), .SW(SW), .BIT(RW-1-g), .PW(PW)) u_sq (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_valid(s_v[g]), .i_rem(s_rem[g]), .i_root(s_root[g]), .i_pass(s_pass[g]),
            .o_valid(s_v[g+1]), .o_rem(s_rem[g+1]), .o_root(s_root[g+1]),
            .o_pass(s_pass[g+1])
        );
    end

    // divide chain: dividend mag << FRAC_BITS; flags = {zero, neg[2:0]}
    logic          d_v     [QB+1];
    logic [RW-1:0] d_den   [QB+1];
    logic [NW-1:0] d_rem   [QB+1][3];
    logic [NW-1:0] d_quo   [QB+1][3];
    logic [3:0]    d_flags [QB+1];

    logic [PW-1:0] w_sp;
    assign w_sp       = s_pass[RW];
    assign d_v[0]     = s_v[RW];
    assign d_den[0]   = s_root[RW];
    assign d_flags[0] = {(s_root[RW] == '0), w_sp[PW-1 -: 3]};
    for (genvar k = 0; k < 3; k++) begin : g_dinit
        assign d_rem[0][k] = {w_sp[k*MW +: MW], {FRAC_BITS{1'b0}}};
        assign d_quo[0][k] = '0;
    end

    for (genvar g = 0; g < QB; g++) begin : g_div
        v3n_div_stage #(.NW(NW), .DW(RW), .BIT(QB-1-g)) u_dv (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_valid(d_v[g]), .i_den(d_den[g]), .i_rem(d_rem[g]), .i_quo(d_quo[g]),
            .i_flags(d_flags[g]),
            .o_valid(d_v[g+1]), .o_den(d_den[g+1]), .o_rem(d_rem[g+1]),
            .o_quo(d_quo[g+1]), .o_flags(d_flags[g+1])
        );
    end

    // output register: saturate, apply sign, zero vector
    logic [OW-1:0] r_unit [3];
    logic          r_zero;
    logic          r_ov;
    localparam logic [OW-1:0] ONE = OW'(1) << FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= d_v[QB];
        end
        if (w_en) begin
            r_zero <= d_flags[QB][3];
            for (int k = 0; k < 3; k++) begin
                logic [OW-1:0] q;
                q = (d_quo[QB][k] > NW'(ONE)) ? ONE : OW'(d_quo[QB][k]);
                if (d_flags[QB][3]) begin
                    r_unit[k] <= '0;
                end else begin
                    r_unit[k] <= d_flags[QB][k] ? OW'(-q) : q;
                end
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = (OBYTES*8)'({r_zero, r_unit[2], r_unit[1], r_unit[0]});

endmodule
